// File: hw/rtl/fmu_pkg.sv
// fmu_pkg: operation, FSM state and status codes and field widths of the mutex unit.
// Used by fifo_mutex_unit. No dependencies.
package fmu_pkg;

	typedef enum logic [1:0] {
		FN_INIT   = 2'd0,
		FN_LOCK   = 2'd1,
		FN_TRY    = 2'd2,
		FN_UNLOCK = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_META = 3'b010,
		ST_POP  = 3'b100
	} fsm_t;

	localparam int StatusW = 3;
	localparam int TaskW   = 4;
	localparam int IndexW  = 4;

	localparam logic [StatusW-1:0] STS_INITIALIZED = 3'd0;
	localparam logic [StatusW-1:0] STS_ACQUIRED    = 3'd1;
	localparam logic [StatusW-1:0] STS_BLOCKED     = 3'd2;
	localparam logic [StatusW-1:0] STS_QUEUE_FULL  = 3'd3;
	localparam logic [StatusW-1:0] STS_BUSY        = 3'd4;
	localparam logic [StatusW-1:0] STS_FREED       = 3'd5;
	localparam logic [StatusW-1:0] STS_HANDED      = 3'd6;

endpackage

// File: hw/rtl/fifo_mutex_unit.sv
// fifo_mutex_unit: bank of mutexes, each with a lock bit and a FIFO ring of waiters.
// Depends on fmu_pkg and fmu_ram.
//
// Flow: IDLE accepts a request and reads its entry from the state memory; META computes
// and registers the result; a handover unlock reads the waiter ring and finishes in POP.
// A new request is taken only in IDLE, after the read-modify-write has committed.
// Reset: all mutexes free with empty queues at once (per-entry valid bits); no sweep.
module fifo_mutex_unit
	import fmu_pkg::*;
#(
	parameter int NUM_TASKS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         func,
	input  logic [IndexW-1:0]  mutex_index,
	input  logic [TaskW-1:0]   requester_task,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [StatusW-1:0] status,
	output logic               woken_valid,
	output logic [TaskW-1:0]   woken_task
);

	localparam int MW  = (NUM_TASKS > 2) ? $clog2(NUM_TASKS) : 1;
	localparam int CW  = $clog2(NUM_TASKS + 1);
	localparam int MEW = 1 + CW + MW;
	localparam int SAW = 2 * MW;

	function automatic logic [MW-1:0] wrap_idx(logic [IndexW-1:0] v);
		logic [6:0] r;
		r = 7'(v);
		for (int i = 0; i < 8; i++) begin
			if (r >= 7'(NUM_TASKS)) begin
				r = r - 7'(NUM_TASKS);
			end
		end
		return r[MW-1:0];
	endfunction

	fsm_t               state_q;
	logic [1:0]         func_q;
	logic [MW-1:0]      addr_q;
	logic [TaskW-1:0]   task_q;
	logic [NUM_TASKS-1:0] meta_vld_q;
	logic               meta_vld_s1;

	logic               accept;
	logic [MW-1:0]      acc_addr;
	logic [MEW-1:0]     meta_rdata;
	logic [MEW-1:0]     meta_cur;
	logic               cur_lock;
	logic [CW-1:0]      cur_cnt;
	logic [MW-1:0]      cur_head;
	logic               full;
	logic [MW:0]        slot_sum;
	logic [MW-1:0]      slot;
	logic [MW-1:0]      head_nx;

	logic               meta_we;
	logic [MEW-1:0]     meta_wdata;
	logic               st_we;
	logic [SAW-1:0]     st_waddr;
	logic               st_re;
	logic [TaskW-1:0]   st_rdata;
	logic               done;
	logic               go_pop;
	logic               out_free;
	logic               commit;
	logic [StatusW-1:0] res_status;
	logic               res_wv;
	logic [TaskW-1:0]   res_wt;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign acc_addr  = (func_t'(func) == FN_INIT) ? wrap_idx(requester_task)
	                                              : wrap_idx(mutex_index);
	assign out_free  = !rsp_valid || !rsp_stall;
	assign commit    = done && out_free;

	assign meta_cur = meta_vld_s1 ? meta_rdata : '0;
	assign cur_lock = meta_cur[MEW-1];
	assign cur_cnt  = meta_cur[MW +: CW];
	assign cur_head = meta_cur[MW-1:0];
	assign full     = (cur_cnt >= CW'(NUM_TASKS));
	assign slot_sum = {1'b0, cur_head} + (MW+1)'(cur_cnt);
	assign slot     = (slot_sum >= (MW+1)'(NUM_TASKS)) ?
	                  MW'(slot_sum - (MW+1)'(NUM_TASKS)) : slot_sum[MW-1:0];
	assign head_nx  = (cur_head == MW'(NUM_TASKS - 1)) ? '0 : cur_head + 1'b1;
	assign st_waddr = {addr_q, slot};

	always_comb begin
		meta_we    = 1'b0;
		meta_wdata = meta_cur;
		st_we      = 1'b0;
		st_re      = 1'b0;
		done       = 1'b0;
		go_pop     = 1'b0;
		res_status = STS_INITIALIZED;
		res_wv     = 1'b0;
		res_wt     = '0;
		if (state_q == ST_META) begin
			unique case (func_t'(func_q))
				FN_INIT: begin
					done       = 1'b1;
					meta_we    = 1'b1;
					meta_wdata = '0;
					res_status = STS_INITIALIZED;
				end
				FN_LOCK: begin
					done = 1'b1;
					priority if (!cur_lock) begin
						meta_we             = 1'b1;
						meta_wdata[MEW-1]   = 1'b1;
						res_status          = STS_ACQUIRED;
					end else if (full) begin
						res_status = STS_QUEUE_FULL;
					end else begin
						meta_we              = 1'b1;
						st_we                = 1'b1;
						meta_wdata[MW +: CW] = cur_cnt + 1'b1;
						res_status           = STS_BLOCKED;
					end
				end
				FN_TRY: begin
					done = 1'b1;
					if (!cur_lock) begin
						meta_we           = 1'b1;
						meta_wdata[MEW-1] = 1'b1;
						res_status        = STS_ACQUIRED;
					end else begin
						res_status = STS_BUSY;
					end
				end
				FN_UNLOCK: begin
					if (cur_cnt != '0) begin
						st_re  = 1'b1;
						go_pop = 1'b1;
					end else begin
						done              = 1'b1;
						meta_we           = 1'b1;
						meta_wdata[MEW-1] = 1'b0;
						res_status        = STS_FREED;
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_POP) begin
			done       = 1'b1;
			meta_we    = 1'b1;
			meta_wdata = {1'b1, CW'(cur_cnt - 1'b1), head_nx};
			res_status = STS_HANDED;
			res_wv     = 1'b1;
			res_wt     = st_rdata;
		end
	end

	fmu_ram #(
		.WIDTH(MEW),
		.DEPTH(NUM_TASKS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we && commit),
		.waddr (addr_q),
		.wdata (meta_wdata),
		.re    (accept),
		.raddr (acc_addr),
		.rdata (meta_rdata)
	);

	fmu_ram #(
		.WIDTH(TaskW),
		.DEPTH(1 << SAW)
	) u_wait_ram (
		.clk   (clk),
		.we    (st_we && commit),
		.waddr (st_waddr),
		.wdata (task_q),
		.re    (st_re),
		.raddr ({addr_q, cur_head}),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			meta_vld_q <= '0;
			rsp_valid  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					priority if (go_pop) begin
						state_q <= ST_POP;
					end else if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (meta_we && commit) begin
				meta_vld_q[addr_q] <= 1'b1;
			end
			if (commit) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= func;
			addr_q      <= acc_addr;
			task_q      <= requester_task;
			meta_vld_s1 <= meta_vld_q[acc_addr];
		end
		if (commit) begin
			status      <= res_status;
			woken_valid <= res_wv;
			woken_task  <= res_wt;
		end
	end

endmodule

// File: hw/rtl/fmu_ram.sv
// fmu_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
module fmu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
